// File: rtl/emm_pkg.sv
`default_nettype none

package emm_pkg;

   // Memory sizes; the data memory depth is a power of two.
   localparam int DATA_DEPTH = 65536;
   localparam int FILE_DEPTH = 256;
   localparam int DATA_AW    = $clog2(DATA_DEPTH);
   localparam int FILE_AW    = $clog2(FILE_DEPTH);

   // Word widths on the streams.
   localparam int REQ_W = 16;
   localparam int RSP_W = 56;

   // Whole opcodes with their own meaning.
   localparam logic [7:0] OP_JUMP  = 8'h07;
   localparam logic [7:0] OP_JUMPZ = 8'h17;
   localparam logic [7:0] OP_NOP   = 8'hFF;

   // Source codes (opcode high nibble).
   localparam logic [3:0] SRC_IMM   = 4'h0;
   localparam logic [3:0] SRC_ALU   = 4'h1;
   localparam logic [3:0] SRC_FILE  = 4'h2;
   localparam logic [3:0] SRC_MEM   = 4'h3;
   localparam logic [3:0] SRC_PORT0 = 4'h4;
   localparam logic [3:0] SRC_PORT1 = 4'h5;

   // Destination codes (opcode low nibble).
   localparam logic [3:0] DST_FILE    = 4'h0;
   localparam logic [3:0] DST_A       = 4'h1;
   localparam logic [3:0] DST_ADDR0   = 4'h2;
   localparam logic [3:0] DST_ADDR1   = 4'h3;
   localparam logic [3:0] DST_ADDR2   = 4'h4;
   localparam logic [3:0] DST_FP      = 4'h5;
   localparam logic [3:0] DST_B       = 4'h6;
   localparam logic [3:0] DST_MEM     = 4'h8;
   localparam logic [3:0] DST_ALUFILE = 4'h9;
   localparam logic [3:0] DST_PORT0   = 4'hA;
   localparam logic [3:0] DST_PORT1   = 4'hB;

   // ALU modes.
   localparam logic [7:0] ALU_ADD  = 8'd0;
   localparam logic [7:0] ALU_SUB  = 8'd1;
   localparam logic [7:0] ALU_ADC  = 8'd2;
   localparam logic [7:0] ALU_SBB  = 8'd3;
   localparam logic [7:0] ALU_NE   = 8'd4;
   localparam logic [7:0] ALU_AND  = 8'd5;
   localparam logic [7:0] ALU_OR   = 8'd6;
   localparam logic [7:0] ALU_NOT  = 8'd7;
   localparam logic [7:0] ALU_XOR  = 8'd8;
   localparam logic [7:0] ALU_SHLN = 8'd9;
   localparam logic [7:0] ALU_ASRB = 8'd10;
   localparam logic [7:0] ALU_SHRH = 8'd11;
   localparam logic [7:0] ALU_SHRA = 8'd12;
   localparam logic [7:0] ALU_SHLA = 8'd13;
   localparam logic [7:0] ALU_SHLB = 8'd14;
   localparam logic [7:0] ALU_MULL = 8'd15;
   localparam logic [7:0] ALU_MULH = 8'd16;
   localparam logic [7:0] ALU_DIV  = 8'd17;
   localparam logic [7:0] ALU_MOD  = 8'd18;
   localparam logic [7:0] ALU_INC  = 8'd19;
   localparam logic [7:0] ALU_DEC  = 8'd20;
   localparam logic [7:0] ALU_INCC = 8'd21;
   localparam logic [7:0] ALU_DECC = 8'd22;
   localparam logic [7:0] ALU_PASA = 8'd23;
   localparam logic [7:0] ALU_PASB = 8'd24;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic div_step;
      logic commit;
      logic clr_write;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic clr_last;
   } stat_type;

   // ALU result: bit 8 is the carry. Quotient and remainder come from the divider.
   function automatic logic [8:0] alu_eval(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] mode, input logic cin,
                                           input logic [7:0] quo, input logic [7:0] rem);
      logic [8:0]  t;
      logic [15:0] p;
      logic [7:0]  r;
      logic        c;
      p = {8'd0, a} * {8'd0, b};
      t = 9'd0;
      r = a;
      c = 1'b0;
      case (mode)
         ALU_ADD:  begin t = {1'b0, a} + {1'b0, b}; r = t[7:0]; c = t[8]; end
         ALU_SUB:  begin t = {1'b0, a} - {1'b0, b}; r = t[7:0]; c = t[8]; end
         ALU_ADC:  begin
            t = {1'b0, a} + {1'b0, b} + {8'd0, cin}; r = t[7:0]; c = t[8];
         end
         ALU_SBB:  begin
            t = {1'b0, a} - {1'b0, b} - {8'd0, cin}; r = t[7:0]; c = t[8];
         end
         ALU_NE:   r = {7'd0, a != b};
         ALU_AND:  r = a & b;
         ALU_OR:   r = a | b;
         ALU_NOT:  r = ~a;
         ALU_XOR:  r = a ^ b;
         ALU_SHLN: r = {a[7:4], a[2:0], 1'b0};
         ALU_ASRB: r = {b[7], b[7:1]};
         ALU_SHRH: r = {1'b0, a[7:1]} | (a & 8'hF0);
         ALU_SHRA: r = {1'b0, a[7:1]};
         ALU_SHLA: r = {a[6:0], 1'b0};
         ALU_SHLB: r = {b[6:0], 1'b0};
         ALU_MULL: r = p[7:0];
         ALU_MULH: r = p[15:8];
         ALU_DIV:  r = (b == 8'd0) ? 8'hFF : quo;
         ALU_MOD:  r = (b == 8'd0) ? a : rem;
         ALU_INC:  begin t = {1'b0, a} + 9'd1; r = t[7:0]; c = t[8]; end
         ALU_DEC:  begin t = {1'b0, a} - 9'd1; r = t[7:0]; c = t[8]; end
         ALU_INCC: begin t = {1'b0, a} + 9'd1 + {8'd0, cin}; r = t[7:0]; c = t[8]; end
         ALU_DECC: begin t = {1'b0, a} - 9'd1 - {8'd0, cin}; r = t[7:0]; c = t[8]; end
         ALU_PASA: r = a;
         ALU_PASB: r = b;
         default:  r = a;
      endcase
      return {c, r};
   endfunction

endpackage

`default_nettype wire

// File: rtl/eight_bit_move_machine_core_top.sv
// Each accepted word is captured in S_IDLE, passes S_DIV, where the 8-step restoring
// divider runs when the operand byte selects ALU divide or modulo, and commits in S_EXEC.
// A new word is taken only in S_IDLE, after the last one commits; it is taken while a
// result still waits, and the core then waits only to commit. Reset (synchronous,
// active high) clears the architectural and controller state, then all DATA_DEPTH
// (65536) data memory addresses are swept to zero before the first word is accepted.
`default_nettype none

module eight_bit_move_machine_core_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // instr_word[15:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata   // fetch_address[31:0], port0_value[39:32],
                                        // port0_driven[40], port1_value[48:41],
                                        // port1_driven[49], zeros above
);

   import emm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   emm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .stat       (stat),
      .cmd        (cmd),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   emm_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: rtl/emm_ram.sv
`default_nettype none

module emm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// File: rtl/emm_datapath.sv
`default_nettype none

module emm_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire emm_pkg::cmd_type        cmd,
   output emm_pkg::stat_type            stat,
   input  wire logic [emm_pkg::REQ_W-1:0] req_tdata,
   output logic      [emm_pkg::RSP_W-1:0] rsp_tdata
);

   import emm_pkg::*;

   logic [31:0] pc_ff, pc_in;
   logic [7:0]  a_ff, b_ff, fp_ff, ad0_ff, ad1_ff, ad2_ff;
   logic [7:0]  p0_ff, p1_ff;
   logic        p0en_ff, p1en_ff;
   logic [8:0]  alu_ff;
   logic [FILE_DEPTH-1:0] rfv_ff;
   logic [DATA_AW-1:0]    clr_ff;
   logic [15:0] instr_ff;
   logic [7:0]  quo_ff, quo_in;
   logic [8:0]  rem_ff, rem_in;
   logic [8:0]  shifted;

   logic [7:0]  op, xx;
   logic [3:0]  src_sel, dst_sel;
   logic [23:0] full_addr;
   logic [DATA_AW-1:0] daddr;
   logic [8:0]  alu;
   logic [7:0]  src, rf_rdata, rf_val, dm_rdata;
   logic        src_ok, normal;
   logic        rf_we, dm_we;
   logic [7:0]  rf_wdata, dm_wdata;
   logic [DATA_AW-1:0] dm_waddr;

   // Instruction decode.
   assign op        = instr_ff[15:8];
   assign xx        = instr_ff[7:0];
   assign src_sel   = instr_ff[15:12];
   assign dst_sel   = instr_ff[11:8];
   assign full_addr = {ad2_ff, ad1_ff, ad0_ff};
   assign daddr     = full_addr[DATA_AW-1:0];
   assign alu       = alu_eval(a_ff, b_ff, xx, alu_ff[8], quo_ff, rem_ff[7:0]);
   assign rf_val    = rfv_ff[fp_ff] ? rf_rdata : 8'd0;

   assign stat.need_div = (xx == ALU_DIV) || (xx == ALU_MOD);
   assign stat.clr_last = (clr_ff == {DATA_AW{1'b1}});

   // Source selection.
   always_comb begin
      src    = 8'd0;
      src_ok = 1'b1;
      case (src_sel)
         SRC_IMM:   src = xx;
         SRC_ALU:   src = alu[7:0];
         SRC_FILE:  src = rf_val;
         SRC_MEM:   src = dm_rdata;
         SRC_PORT0: src = p0_ff;
         SRC_PORT1: src = p1_ff;
         default:   src_ok = 1'b0;
      endcase
   end

   assign normal = src_ok && (op != OP_JUMP) && (op != OP_JUMPZ) && (op != OP_NOP);

   // Next fetch address.
   always_comb begin
      pc_in = pc_ff + 32'd2;
      if (op == OP_JUMP || (op == OP_JUMPZ && !alu[0])) begin
         pc_in = {7'd0, full_addr, 1'b0};
      end
   end

   // Memory write ports; the data memory is swept to zero after reset.
   assign rf_we    = cmd.commit && normal && (dst_sel == DST_FILE || dst_sel == DST_ALUFILE);
   assign rf_wdata = (dst_sel == DST_ALUFILE) ? alu[7:0] : src;
   assign dm_we    = cmd.clr_write || (cmd.commit && normal && dst_sel == DST_MEM);
   assign dm_waddr = cmd.clr_write ? clr_ff : daddr;
   assign dm_wdata = cmd.clr_write ? 8'd0 : src;

   // One restoring division step.
   assign shifted = {rem_ff[7:0], quo_ff[7]};
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.capture) begin
         quo_in = a_ff;
         rem_in = 9'd0;
      end else if (cmd.div_step) begin
         if (shifted >= {1'b0, b_ff}) begin
            rem_in = shifted - {1'b0, b_ff};
            quo_in = {quo_ff[6:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[6:0], 1'b0};
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.capture) begin
         instr_ff <= req_tdata;
      end
   end

   // Architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= 32'd0;
         a_ff    <= 8'd0;
         b_ff    <= 8'd0;
         fp_ff   <= 8'd0;
         ad0_ff  <= 8'd0;
         ad1_ff  <= 8'd0;
         ad2_ff  <= 8'd0;
         p0_ff   <= 8'hFF;
         p1_ff   <= 8'hFF;
         p0en_ff <= 1'b0;
         p1en_ff <= 1'b0;
         alu_ff  <= 9'd0;
         rfv_ff  <= '0;
         clr_ff  <= '0;
      end else begin
         if (cmd.clr_write) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.commit) begin
            pc_ff <= pc_in;
            if (src_sel == SRC_ALU || op == OP_JUMPZ || (normal && dst_sel == DST_ALUFILE)) begin
               alu_ff <= alu;
            end
            if (rf_we) begin
               rfv_ff[fp_ff] <= 1'b1;
            end
            if (normal) begin
               case (dst_sel)
                  DST_A:     a_ff   <= src;
                  DST_ADDR0: ad0_ff <= src;
                  DST_ADDR1: ad1_ff <= src;
                  DST_ADDR2: ad2_ff <= src;
                  DST_FP:    fp_ff  <= src;
                  DST_B:     b_ff   <= src;
                  DST_PORT0: begin p0_ff <= src; p0en_ff <= 1'b1; end
                  DST_PORT1: begin p1_ff <= src; p1en_ff <= 1'b1; end
                  default:   ;
               endcase
            end
         end
      end
   end

   emm_ram #(.WIDTH(8), .DEPTH(FILE_DEPTH)) u_file (
      .clock (clock),
      .we    (rf_we),
      .waddr (fp_ff[FILE_AW-1:0]),
      .wdata (rf_wdata),
      .raddr (fp_ff[FILE_AW-1:0]),
      .rdata (rf_rdata)
   );

   emm_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data (
      .clock (clock),
      .we    (dm_we),
      .waddr (dm_waddr),
      .wdata (dm_wdata),
      .raddr (daddr),
      .rdata (dm_rdata)
   );

   // Result word reflects the committed state; it holds until the next commit.
   assign rsp_tdata = {6'd0, p1en_ff, p1_ff, p0en_ff, p0_ff, pc_ff};

endmodule

`default_nettype wire

// File: rtl/emm_ctrl.sv
`default_nettype none

module emm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire emm_pkg::stat_type stat,
   output emm_pkg::cmd_type       cmd,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready
);

   import emm_pkg::*;

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_DIV, S_EXEC} state_type;

   state_type  state_ff;
   logic [2:0] cnt_ff;
   logic       rsp_v_ff;
   logic       slot_free;

   assign slot_free     = !rsp_v_ff || rsp_tready;
   assign req_tready    = (state_ff == S_IDLE);
   assign rsp_tvalid    = rsp_v_ff;
   assign cmd.clr_write = (state_ff == S_CLEAR);
   assign cmd.capture   = (state_ff == S_IDLE) && req_tvalid;
   assign cmd.div_step  = (state_ff == S_DIV) && stat.need_div;
   assign cmd.commit    = (state_ff == S_EXEC) && slot_free;

   // Sequencer and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= 3'd0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               if (stat.clr_last) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_DIV;
                  cnt_ff   <= 3'd0;
               end
            end
            S_DIV: begin
               if (!stat.need_div || cnt_ff == 3'd7) begin
                  state_ff <= S_EXEC;
               end
               cnt_ff <= cnt_ff + 3'd1;
            end
            S_EXEC: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> slot_free) else $error("commit with result slot busy");
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid) else $error("committed word not offered");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("second word taken early");
   a_no_clear_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_write |-> !req_tready) else $error("word taken during clear");

endmodule

`default_nettype wire
